// ===== design/four_level_page_table_walker_unit_assert.svh =====
// Assertion macros used by the checker file of the walker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

// Clocked assertion that is disabled while reset is asserted.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ptw_pkg.sv =====
package ptw_pkg;

    localparam int ADDR_W        = 52;
    localparam int VA_W          = 48;
    localparam int PTE_W         = 64;
    localparam int SIZE_W        = 6;
    localparam int IDX_W         = 9;
    localparam int OFFSET_BITS_4K = 12;
    localparam int PHYS_BITS_DEF = 52;

    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_LARGE_BIT   = 7;

    localparam logic [1:0] LAST_LEVEL = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_LOG_4K  = 6'd12;
    localparam logic [SIZE_W-1:0] SIZE_LOG_2M  = 6'd21;
    localparam logic [SIZE_W-1:0] SIZE_LOG_TOP = 6'd39;

    localparam logic [ADDR_W-1:0] OFF_MASK_L0 = 52'h0_007F_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] OFF_MASK_L1 = 52'h0_0000_3FFF_FFFF;
    localparam logic [ADDR_W-1:0] OFF_MASK_L2 = 52'h0_0000_001F_FFFF;
    localparam logic [ADDR_W-1:0] OFF_MASK_L3 = 52'h0_0000_0000_0FFF;

    typedef enum logic {
        OP_START = 1'b0,
        OP_ENTRY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_STRAY = 2'd3
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] root_table;
        logic [VA_W-1:0]   virt_addr;
        logic [PTE_W-1:0]  table_entry;
    } t_ptw_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic [SIZE_W-1:0] page_size_log;
    } t_ptw_result;

    function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va, logic [1:0] lvl);
        logic [IDX_W-1:0] ix;
        case (lvl)
            2'd0:    ix = va[47:39];
            2'd1:    ix = va[38:30];
            2'd2:    ix = va[29:21];
            default: ix = va[20:12];
        endcase
        return ix;
    endfunction

    function automatic logic [ADDR_W-1:0] off_mask(logic [1:0] lvl);
        logic [ADDR_W-1:0] m;
        case (lvl)
            2'd0:    m = OFF_MASK_L0;
            2'd1:    m = OFF_MASK_L1;
            2'd2:    m = OFF_MASK_L2;
            default: m = OFF_MASK_L3;
        endcase
        return m;
    endfunction

    // A 1 GB page is reported with the 2 MB size.
    function automatic logic [SIZE_W-1:0] size_log(logic [1:0] lvl);
        logic [SIZE_W-1:0] s;
        case (lvl)
            2'd0:    s = SIZE_LOG_TOP;
            2'd1:    s = SIZE_LOG_2M;
            2'd2:    s = SIZE_LOG_2M;
            default: s = SIZE_LOG_4K;
        endcase
        return s;
    endfunction

endpackage

// ===== design/ptw_if.sv =====
interface ptw_in_if import ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] root_table;
    logic [VA_W-1:0]   virt_addr;
    logic [PTE_W-1:0]  table_entry;

    modport source (output valid, op, root_table, virt_addr, table_entry, input ready);
    modport sink   (input valid, op, root_table, virt_addr, table_entry, output ready);
endinterface

interface ptw_out_if import ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [SIZE_W-1:0] page_size_log;

    modport source (output valid, kind, read_addr, phys_addr, page_size_log, input ready);
    modport sink   (input valid, kind, read_addr, phys_addr, page_size_log, output ready);
endinterface

// ===== design/ptw_walk.sv =====
module ptw_walk import ptw_pkg::*; #(
    parameter int PHYS_BITS = PHYS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  t_ptw_item   i_item,
    output t_ptw_result o_result
);

    logic                 r_busy, n_busy;
    logic [1:0]           r_level, n_level;
    logic [VA_W-1:0]      r_vaddr, n_vaddr;

    logic                 w_start;
    logic [PHYS_BITS-1:0] w_next;
    logic [PHYS_BITS-1:0] a_base;
    logic [1:0]           a_level;
    logic [VA_W-1:0]      a_va;
    logic [PHYS_BITS-1:0] w_sum;
    logic [ADDR_W-1:0]    w_frame;
    logic [ADDR_W-1:0]    w_off;
    logic [ADDR_W-1:0]    w_large_pa;
    logic [ADDR_W-1:0]    w_small_pa;

    assign w_start = (i_item.op == OP_START);
    assign w_next  = {i_item.table_entry[PHYS_BITS-1:OFFSET_BITS_4K], {OFFSET_BITS_4K{1'b0}}};

    // The next entry address serves both a new walk and a descent by one level.
    assign a_base  = w_start ? i_item.root_table[PHYS_BITS-1:0] : w_next;
    assign a_level = w_start ? 2'd0 : r_level + 2'd1;
    assign a_va    = w_start ? i_item.virt_addr : r_vaddr;
    assign w_sum   = a_base + PHYS_BITS'({va_index(a_va, a_level), 3'b000});

    assign w_frame    = ADDR_W'(i_item.table_entry[PHYS_BITS-1:0]);
    assign w_off      = off_mask(r_level);
    assign w_large_pa = (w_frame & ~w_off) | (ADDR_W'(r_vaddr) & w_off);
    assign w_small_pa = ADDR_W'(w_next) | ADDR_W'(r_vaddr[OFFSET_BITS_4K-1:0]);

    always_comb begin
        n_busy   = r_busy;
        n_level  = r_level;
        n_vaddr  = r_vaddr;
        o_result = '0;
        if (w_start) begin
            n_busy             = 1'b1;
            n_level            = 2'd0;
            n_vaddr            = i_item.virt_addr;
            o_result.kind      = KIND_READ;
            o_result.read_addr = ADDR_W'(w_sum);
        end else if (!r_busy) begin
            o_result.kind = KIND_STRAY;
        end else if (!i_item.table_entry[PTE_PRESENT_BIT]) begin
            n_busy        = 1'b0;
            n_level       = 2'd0;
            o_result.kind = KIND_FAULT;
        end else if (i_item.table_entry[PTE_LARGE_BIT]) begin
            n_busy                 = 1'b0;
            n_level                = 2'd0;
            o_result.kind          = KIND_DONE;
            o_result.phys_addr     = w_large_pa;
            o_result.page_size_log = size_log(r_level);
        end else if (r_level == LAST_LEVEL) begin
            n_busy                 = 1'b0;
            n_level                = 2'd0;
            o_result.kind          = KIND_DONE;
            o_result.phys_addr     = w_small_pa;
            o_result.page_size_log = SIZE_LOG_4K;
        end else begin
            n_level            = a_level;
            o_result.kind      = KIND_READ;
            o_result.read_addr = ADDR_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= 2'd0;
        end else if (i_advance) begin
            r_busy  <= n_busy;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_vaddr <= n_vaddr;
        end
    end

endmodule

// ===== design/four_level_page_table_walker_unit.sv =====
// Four-level page table walker. Each input transaction is either a walk start (root table
// address and virtual address) or a table entry fetched for the walk in progress, and each
// gives exactly one result transaction: a read request for the next entry, a finished
// translation with its page size, a not-present fault, or a flag for an entry that arrived
// with no walk in progress. A transaction is registered at the input, then handled against the
// walk state and placed in the result register once that register is empty or being taken;
// one transaction is taken every cycle while the result side keeps up. A new start drops any
// walk in progress.
module four_level_page_table_walker_unit import ptw_pkg::*; #(
    parameter int PHYS_BITS = PHYS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptw_in_if.sink    i_in,
    ptw_out_if.source o_out
);

    logic        r_in_valid;
    t_ptw_item   r_in;
    logic        r_out_valid;
    t_ptw_result r_out;
    logic        w_advance;
    t_ptw_result w_result;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.op          <= t_op'(i_in.op);
            r_in.root_table  <= i_in.root_table;
            r_in.virt_addr   <= i_in.virt_addr;
            r_in.table_entry <= i_in.table_entry;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    ptw_walk #(
        .PHYS_BITS (PHYS_BITS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in),
        .o_result  (w_result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.read_addr     = r_out.read_addr;
    assign o_out.phys_addr     = r_out.phys_addr;
    assign o_out.page_size_log = r_out.page_size_log;

endmodule

// ===== design/ptw_checker.sv =====
`include "four_level_page_table_walker_unit_assert.svh"

module ptw_checker import ptw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_kind             i_kind,
    input logic [ADDR_W-1:0] i_read_addr,
    input logic [ADDR_W-1:0] i_phys_addr,
    input logic [SIZE_W-1:0] i_page_size_log
);

    `PTW_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_read_addr) && $stable(i_phys_addr), "result changed while stalled")

    `PTW_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `PTW_ASSERT(a_done_fields, i_clk, i_rst_n, i_out_valid && i_kind == KIND_DONE |-> i_read_addr == '0 && (i_page_size_log == SIZE_LOG_4K || i_page_size_log == SIZE_LOG_2M || i_page_size_log == SIZE_LOG_TOP), "bad translation fields")

    `PTW_ASSERT(a_other_fields, i_clk, i_rst_n, i_out_valid && i_kind != KIND_DONE |-> i_phys_addr == '0 && i_page_size_log == '0 && (i_kind == KIND_READ || i_read_addr == '0), "nonzero unused result fields")

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_read_addr     (o_out.read_addr),
    .i_phys_addr     (o_out.phys_addr),
    .i_page_size_log (o_out.page_size_log)
);

// ===== tb/four_level_page_table_walker_unit_test.sv =====
module four_level_page_table_walker_unit_test;
    import ptw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_SHIFT   = 39;
    localparam int LEVEL_BITS  = 9;
    localparam int GB_SHIFT    = 30;
    localparam int TOTAL_ITEMS = 550;
    localparam int IDLE_PCT    = 16;

    class walk_tracker;
        t_ptw_result       pending_results[$];
        bit                busy;
        logic [1:0]        level;
        logic [VA_W-1:0]   vaddr;
        logic [ADDR_W-1:0] base;
        int                mismatch_count;
        int                start_count;
        int                read_count;
        int                done_count;
        int                fault_count;
        int                stray_count;

        function logic [ADDR_W-1:0] entry_address();
            logic [IDX_W-1:0] ix;
            ix = IDX_W'(vaddr >> (TOP_SHIFT - LEVEL_BITS * level));
            return base + {ix, 3'b000};
        endfunction

        function t_ptw_result walk_step(t_ptw_item it);
            t_ptw_result       r;
            int                sh;
            logic [ADDR_W-1:0] off;
            logic [ADDR_W-1:0] frame;
            r = '0;
            r.kind = KIND_READ;
            sh = TOP_SHIFT - LEVEL_BITS * level;
            off = (52'd1 << sh) - 52'd1;
            frame = it.table_entry[ADDR_W-1:0];
            if (it.op == OP_START) begin
                busy = 1'b1;
                level = 2'd0;
                vaddr = it.virt_addr;
                base = it.root_table;
                r.read_addr = entry_address();
            end else if (!busy) begin
                r.kind = KIND_STRAY;
            end else if (!it.table_entry[PTE_PRESENT_BIT]) begin
                busy = 1'b0;
                level = 2'd0;
                r.kind = KIND_FAULT;
            end else if (it.table_entry[PTE_LARGE_BIT]) begin
                r.kind = KIND_DONE;
                r.phys_addr = (frame & ~off) | (ADDR_W'(vaddr) & off);
                r.page_size_log = (sh == GB_SHIFT) ? SIZE_LOG_2M : SIZE_W'(sh);
                busy = 1'b0;
                level = 2'd0;
            end else if (level == LAST_LEVEL) begin
                r.kind = KIND_DONE;
                r.phys_addr = {frame[ADDR_W-1:OFFSET_BITS_4K], vaddr[OFFSET_BITS_4K-1:0]};
                r.page_size_log = SIZE_LOG_4K;
                busy = 1'b0;
                level = 2'd0;
            end else begin
                base = {frame[ADDR_W-1:OFFSET_BITS_4K], {OFFSET_BITS_4K{1'b0}}};
                level = level + 2'd1;
                r.read_addr = entry_address();
            end
            return r;
        endfunction

        function void note_item(t_ptw_item it);
            if (it.op == OP_START) start_count++;
            pending_results.push_back(walk_step(it));
        endfunction

        function void report(string what, t_ptw_result exp, t_ptw_result got);
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%s: expected kind %0d read %h phys %h size %0d, got kind %0d read %h phys %h size %0d",
                         what, exp.kind, exp.read_addr, exp.phys_addr, exp.page_size_log,
                         got.kind, got.read_addr, got.phys_addr, got.page_size_log);
            end
        endfunction

        function void check_result(t_ptw_result got);
            t_ptw_result exp;
            if (pending_results.size() == 0) begin
                report("Unexpected result", '0, got);
                return;
            end
            exp = pending_results.pop_front();
            case (exp.kind)
                KIND_READ:  read_count++;
                KIND_DONE:  done_count++;
                KIND_FAULT: fault_count++;
                default:    stray_count++;
            endcase
            if (got.kind !== exp.kind || got.read_addr !== exp.read_addr ||
                got.phys_addr !== exp.phys_addr || got.page_size_log !== exp.page_size_log) begin
                report("Result mismatch", exp, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady_phase;
    int   sent_count;

    walk_tracker tracker = new;

    ptw_in_if  walk_in ();
    ptw_out_if walk_out ();

    four_level_page_table_walker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (walk_in),
        .o_out   (walk_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ADDR_W-1:0] rand_root();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return ADDR_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return VA_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [PTE_W-1:0] rand_entry();
        return {$urandom, $urandom};
    endfunction

    function automatic t_ptw_item make_start(logic [ADDR_W-1:0] root, logic [VA_W-1:0] va);
        t_ptw_item it;
        it.op = OP_START;
        it.root_table = root;
        it.virt_addr = va;
        it.table_entry = rand_entry();
        return it;
    endfunction

    function automatic t_ptw_item make_entry(logic [PTE_W-1:0] e);
        t_ptw_item it;
        it.op = OP_ENTRY;
        it.root_table = ADDR_W'({$urandom, $urandom});
        it.virt_addr = VA_W'({$urandom, $urandom});
        it.table_entry = e;
        return it;
    endfunction

    function automatic logic [PTE_W-1:0] table_link();
        logic [PTE_W-1:0] e;
        e = rand_entry();
        e[PTE_PRESENT_BIT] = 1'b1;
        e[PTE_LARGE_BIT] = 1'b0;
        return e;
    endfunction

    task automatic send_item(input t_ptw_item it);
        while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
            walk_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        walk_in.valid <= 1'b1;
        walk_in.op <= it.op;
        walk_in.root_table <= it.root_table;
        walk_in.virt_addr <= it.virt_addr;
        walk_in.table_entry <= it.table_entry;
        @(posedge i_clk);
        while (!walk_in.ready) @(posedge i_clk);
        tracker.note_item(it);
        sent_count++;
    endtask

    task automatic run_walk();
        int               last_level;
        int               pick;
        logic [PTE_W-1:0] e;
        send_item(make_start(rand_root(), rand_va()));
        last_level = $urandom_range(3);
        for (int lvl = 0; lvl < last_level; lvl++) send_item(make_entry(table_link()));
        e = table_link();
        pick = $urandom_range(9);
        if (pick < 2) begin
            e[PTE_PRESENT_BIT] = 1'b0;
        end else if (pick < 6) begin
            e[PTE_LARGE_BIT] = 1'b1;
        end
        send_item(make_entry(e));
    endtask

    task automatic run_noise();
        int pick;
        pick = $urandom_range(1);
        if (pick == 0) begin
            send_item(make_entry(rand_entry()));
        end else begin
            send_item(make_start(rand_root(), rand_va()));
            repeat ($urandom_range(2)) send_item(make_entry(rand_entry()));
        end
    endtask

    task automatic run_directed();
        send_item(make_entry('1));
        send_item(make_start('1, '1));
        send_item(make_entry(~64'h80));
        send_item(make_entry('1));
        send_item(make_start('0, '0));
        send_item(make_entry(64'h81));
        send_item(make_start(rand_root(), rand_va()));
        send_item(make_entry(64'h1));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_F001));
        send_item(make_entry(table_link() | 64'h80));
        send_item(make_start(rand_root(), rand_va()));
        repeat (3) send_item(make_entry(table_link()));
        send_item(make_entry(table_link() | 64'h80));
        send_item(make_start(rand_root(), rand_va()));
        repeat (4) send_item(make_entry(table_link()));
        send_item(make_start(rand_root(), rand_va()));
        send_item(make_entry(64'h0));
        send_item(make_entry(table_link()));
        send_item(make_start(rand_root(), rand_va()));
        send_item(make_entry(table_link()));
        send_item(make_start(rand_root(), rand_va()));
    endtask

    task automatic wait_drained();
        walk_in.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_ptw_result got;
        walk_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && walk_out.valid && walk_out.ready) begin
                got.kind = walk_out.kind;
                got.read_addr = walk_out.read_addr;
                got.phys_addr = walk_out.phys_addr;
                got.page_size_log = walk_out.page_size_log;
                tracker.check_result(got);
            end
            walk_out.ready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int pick;
        i_rst_n <= 1'b0;
        walk_in.valid <= 1'b0;
        walk_in.op <= OP_START;
        walk_in.root_table <= '0;
        walk_in.virt_addr <= '0;
        walk_in.table_entry <= '0;
        steady_phase = 1'b0;
        sent_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();

        while (sent_count < TOTAL_ITEMS) begin
            steady_phase = (sent_count >= 250 && sent_count < 350);
            pick = $urandom_range(9);
            if (pick < 8) begin
                run_walk();
            end else begin
                run_noise();
            end
        end
        steady_phase = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d walk starts over %0d transactions at every table level.",
                 tracker.start_count, sent_count);
        $display("Checked %0d read requests, %0d translations, %0d faults, %0d stray entries.",
                 tracker.read_count, tracker.done_count, tracker.fault_count,
                 tracker.stray_count);
        if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout waiting for the walker.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ptw_pkg.sv
design/ptw_if.sv
design/ptw_walk.sv
design/four_level_page_table_walker_unit.sv
design/ptw_checker.sv
tb/four_level_page_table_walker_unit_test.sv
